// ===== hw/rtl/vfd_pkg.sv =====
// ----------------------------------------------------------------------------
// VFD scanner package
// Request codes, register indexes, driver bit map, font and grid tables.
// ----------------------------------------------------------------------------
package vfd_pkg;

    // Number of digit positions the buffer can hold
    localparam int MAX_DIGITS_DEF = 10;

    localparam int WORD_W     = 20;
    localparam int POS_W      = 4;
    localparam int TICK_W     = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [3:0]        DIGIT_COUNT_RST   = 4'd10;
    localparam logic [TICK_W-1:0] SCAN_INTERVAL_RST = 16'd500;

    // Request kinds carried in the input tuser
    typedef enum logic [1:0] {
        REQ_SET_CHAR = 2'd0,
        REQ_SET_SEGS = 2'd1,
        REQ_CLEAR    = 2'd2,
        REQ_TICK     = 2'd3
    } req_t;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_DIGIT_COUNT   = 1'b0;
    localparam logic REG_SCAN_INTERVAL = 1'b1;

    // Segment positions on the driver word
    localparam logic [WORD_W-1:0] SEG_A   = 20'h00080;
    localparam logic [WORD_W-1:0] SEG_B   = 20'h00040;
    localparam logic [WORD_W-1:0] SEG_C   = 20'h00010;
    localparam logic [WORD_W-1:0] SEG_D   = 20'h40000;
    localparam logic [WORD_W-1:0] SEG_E   = 20'h08000;
    localparam logic [WORD_W-1:0] SEG_F   = 20'h04000;
    localparam logic [WORD_W-1:0] SEG_G   = 20'h01000;
    localparam logic [WORD_W-1:0] SEG_DOT = 20'h00008;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Grid select bit for each digit position
    function automatic logic [WORD_W-1:0] grid_bit(input logic [POS_W-1:0] digit);
        logic [WORD_W-1:0] g;
        unique case (digit)
            4'd0:    g = 20'h00400;
            4'd1:    g = 20'h00800;
            4'd2:    g = 20'h02000;
            4'd3:    g = 20'h10000;
            4'd4:    g = 20'h80000;
            4'd5:    g = 20'h00002;
            4'd6:    g = 20'h00004;
            4'd7:    g = 20'h00020;
            4'd8:    g = 20'h00100;
            4'd9:    g = 20'h00200;
            default: g = '0;
        endcase
        return g;
    endfunction

    // Map an ASCII code to driver segments: digits, minus sign, else blank
    function automatic logic [WORD_W-1:0] font_lookup(input logic [7:0] ch);
        logic [WORD_W-1:0] f;
        f = '0;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            unique case (4'(ch - CHAR_ZERO))
                4'd0:    f = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
                4'd1:    f = SEG_B | SEG_C;
                4'd2:    f = SEG_A | SEG_B | SEG_G | SEG_E | SEG_D;
                4'd3:    f = SEG_A | SEG_B | SEG_G | SEG_C | SEG_D;
                4'd4:    f = SEG_F | SEG_G | SEG_B | SEG_C;
                4'd5:    f = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
                4'd6:    f = SEG_A | SEG_F | SEG_E | SEG_D | SEG_C | SEG_G;
                4'd7:    f = SEG_A | SEG_B | SEG_C;
                4'd8:    f = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
                4'd9:    f = SEG_A | SEG_F | SEG_G | SEG_B | SEG_C | SEG_D;
                default: f = '0;
            endcase
        end
        else if (ch == CHAR_MINUS)
        begin
            f = SEG_G;
        end
        return f;
    endfunction

    // Remap a standard a..g, dot mask onto the driver bits
    function automatic logic [WORD_W-1:0] mask_remap(input logic [7:0] msk);
        logic [WORD_W-1:0] m;
        m = '0;
        if (msk[0]) m = m | SEG_A;
        if (msk[1]) m = m | SEG_B;
        if (msk[2]) m = m | SEG_C;
        if (msk[3]) m = m | SEG_D;
        if (msk[4]) m = m | SEG_E;
        if (msk[5]) m = m | SEG_F;
        if (msk[6]) m = m | SEG_G;
        if (msk[7]) m = m | SEG_DOT;
        return m;
    endfunction

endpackage

// ===== hw/rtl/vfd_multiplex_scanner.sv =====
// ----------------------------------------------------------------------------
// VFD multiplex scanner
// Digit buffer with char/segment writes and a tick-driven two-phase scan.
// ----------------------------------------------------------------------------
// An accepted request's result is written to the output register, the only
// stage. Throughput: one request per cycle while the output register is free
// or being drained; buffer and scan state update at the accepting edge too.
// Reset: asynchronous active-low rst_n clears the buffer, scan digit, phase,
// tick counter, blank level and output valid; registers return to defaults.
// ----------------------------------------------------------------------------
module vfd_multiplex_scanner #(
    parameter int MAX_DIGITS = vfd_pkg::MAX_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [3:0] position, [11:4] character, [12] dot, [20:13] seg_mask, [23:21] zero
    input  logic [23:0]                     s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                      s_axis_tuser,

    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [19:0] drive_word, [20] blank_level, [23:21] zero
    output logic [23:0]                     m_axis_tdata,
    // [0] word_valid
    output logic [0:0]                      m_axis_tuser,

    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vfd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [vfd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [vfd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int         W       = vfd_pkg::WORD_W;
    localparam int         TW      = vfd_pkg::TICK_W;
    localparam logic [3:0] MAX_CNT = 4'(MAX_DIGITS);

    // Configuration registers
    logic [3:0]    digit_count_reg;
    logic [TW-1:0] scan_interval_reg;

    // Scan state and buffer
    logic [W-1:0]  digit_store_reg  [MAX_DIGITS];
    logic [W-1:0]  digit_store_next [MAX_DIGITS];
    logic [3:0]    scan_digit_reg, scan_digit_next;
    logic          scan_phase_reg, scan_phase_next;
    logic [TW-1:0] tick_count_reg, tick_count_next;
    logic          blank_reg, blank_next;

    // Output register
    logic          out_valid_reg;
    logic [W-1:0]  out_word_reg, out_word_next;
    logic          out_wv_reg, out_wv_next;
    logic          out_blank_reg;

    // Request fields
    vfd_pkg::req_t req;
    logic [3:0]    position;
    logic [7:0]    character;
    logic          dot;
    logic [7:0]    seg_mask;

    logic          in_accept;
    logic          cfg_write;
    logic [3:0]    cnt_eff;
    logic [W-1:0]  new_word;
    logic [W-1:0]  cur_store;
    logic [3:0]    digit_inc;
    logic [TW-1:0] tick_inc;

    assign req       = vfd_pkg::req_t'(s_axis_tuser);
    assign position  = s_axis_tdata[3:0];
    assign character = s_axis_tdata[11:4];
    assign dot       = s_axis_tdata[12];
    assign seg_mask  = s_axis_tdata[20:13];

    // Take a request whenever the output slot is free or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_blank_reg, out_word_reg};
    assign m_axis_tuser  = out_wv_reg;

    // Configuration access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[2] == vfd_pkg::REG_SCAN_INTERVAL)
            prdata = vfd_pkg::CFG_DATA_W'(scan_interval_reg);
        else
            prdata = vfd_pkg::CFG_DATA_W'(digit_count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg   <= vfd_pkg::DIGIT_COUNT_RST;
            scan_interval_reg <= vfd_pkg::SCAN_INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == vfd_pkg::REG_SCAN_INTERVAL)
                scan_interval_reg <= pwdata[TW-1:0];
            else
                digit_count_reg <= pwdata[3:0];
        end
    end

    // Clamp the digit count into 1..MAX_DIGITS
    always_comb
    begin
        if (digit_count_reg == 4'd0)
            cnt_eff = 4'd1;
        else if (digit_count_reg > MAX_CNT)
            cnt_eff = MAX_CNT;
        else
            cnt_eff = digit_count_reg;
    end

    // Word for a buffer write
    always_comb
    begin
        if (req == vfd_pkg::REQ_SET_CHAR)
            new_word = vfd_pkg::font_lookup(character) | (dot ? vfd_pkg::SEG_DOT : '0);
        else
            new_word = vfd_pkg::mask_remap(seg_mask);
    end

    // Select the buffer entry of the digit being scanned
    always_comb
    begin
        cur_store = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (scan_digit_reg == 4'(i))
                cur_store = digit_store_reg[i];
        end
    end

    assign digit_inc = scan_digit_reg + 4'd1;
    assign tick_inc  = tick_count_reg + 16'd1;

    // Next state and result for the request at the input
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
            digit_store_next[i] = digit_store_reg[i];
        scan_digit_next = scan_digit_reg;
        scan_phase_next = scan_phase_reg;
        tick_count_next = tick_count_reg;
        blank_next      = blank_reg;
        out_word_next   = '0;
        out_wv_next     = 1'b0;

        unique case (req)
            vfd_pkg::REQ_SET_CHAR, vfd_pkg::REQ_SET_SEGS:
            begin
                for (int i = 0; i < MAX_DIGITS; i++)
                begin
                    if (position == 4'(i) && position < cnt_eff)
                        digit_store_next[i] = new_word;
                end
            end
            vfd_pkg::REQ_CLEAR:
            begin
                for (int i = 0; i < MAX_DIGITS; i++)
                    digit_store_next[i] = '0;
            end
            vfd_pkg::REQ_TICK:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= scan_interval_reg)
                begin
                    tick_count_next = '0;
                    if (!scan_phase_reg)
                    begin
                        // Send phase: blank, emit grid plus segments, advance digit
                        blank_next      = 1'b1;
                        out_word_next   = vfd_pkg::grid_bit(scan_digit_reg) | cur_store;
                        out_wv_next     = 1'b1;
                        scan_digit_next = (digit_inc >= cnt_eff) ? 4'd0 : digit_inc;
                        scan_phase_next = 1'b1;
                    end
                    else
                    begin
                        // Show phase: unblank
                        blank_next      = 1'b0;
                        scan_phase_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold buffer and scan state, advance on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
                digit_store_reg[i] <= '0;
            scan_digit_reg <= '0;
            scan_phase_reg <= 1'b0;
            tick_count_reg <= '0;
            blank_reg      <= 1'b0;
        end
        else if (in_accept)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
                digit_store_reg[i] <= digit_store_next[i];
            scan_digit_reg <= scan_digit_next;
            scan_phase_reg <= scan_phase_next;
            tick_count_reg <= tick_count_next;
            blank_reg      <= blank_next;
        end
    end

    // Output valid: set on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_word_reg  <= out_word_next;
            out_wv_reg    <= out_wv_next;
            out_blank_reg <= blank_next;
        end
    end

`ifndef SYNTHESIS
    // A newly emitted word always goes out with the display blanked
    a_emit_blanked: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata[20])
        else $error("drive word emitted while display not blanked");

    // Blank level tracks the scan phase
    a_phase_blank: assert property (@(posedge clk) disable iff (!rst_n)
        scan_phase_reg == blank_reg)
        else $error("scan phase and blank level disagree");

    // Scanned digit never leaves the buffer
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_digit_reg < MAX_CNT)
        else $error("scan digit outside the buffer");

    // Tick counter moves only on an accepted request
    a_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(tick_count_reg))
        else $error("tick counter changed without a request");
`endif

endmodule
